@@ design/dwips_pkg.sv @@
// ----------------------------------------------------------------------------
// dwips_pkg
// Shared widths, codes and types of the two-wheel incremental PI speed block.
// ----------------------------------------------------------------------------
package dwips_pkg;

   // Field widths of items and registers.
   localparam int KIND_W   = 2;
   localparam int LERR_W   = 8;
   localparam int SPEED_W  = 24;
   localparam int DUTY_W   = 12;
   localparam int GAIN_W   = 16;
   localparam int BASE_W   = 23;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Internal arithmetic widths.
   localparam int OFF_W    = 25;   // line error times steer gain
   localparam int ERR_W    = 26;   // target minus measured speed
   localparam int OPND_W   = 27;   // change of error
   localparam int HI_W     = 29;   // upper part of the serial product
   localparam int PROD_W   = HI_W + GAIN_W;
   localparam int INC_W    = PROD_W - 8;
   localparam int CNT_W    = 4;

   // Start duty after reset, in PWM counts.
   localparam int START_DUTY_RST = 1300;

   typedef enum logic [KIND_W-1:0] {
      KIND_STRAIGHT = 2'd0,
      KIND_TRACK    = 2'd1,
      KIND_ZERO     = 2'd2,
      KIND_RESTART  = 2'd3
   } kind_type;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_KP    = 3'd0;
   localparam logic [2:0] REG_KI    = 3'd1;
   localparam logic [2:0] REG_BASE  = 3'd2;
   localparam logic [2:0] REG_STEER = 3'd3;
   localparam logic [2:0] REG_START = 3'd4;

   typedef struct packed {
      logic                     start;
      logic [GAIN_W-1:0]        gain_a;
      logic [GAIN_W-1:0]        gain_b;
      logic signed [OPND_W-1:0] opnd_a;
      logic signed [OPND_W-1:0] opnd_b;
   } mac_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mac_stat_type;

endpackage

@@ design/dwips_req_if.sv @@
// ----------------------------------------------------------------------------
// dwips_req_if
// Input item channel: kind, line error and both measured wheel speeds.
// ----------------------------------------------------------------------------
interface dwips_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [dwips_pkg::KIND_W-1:0]         kind;
   logic signed [dwips_pkg::LERR_W-1:0]  line_error;
   logic signed [dwips_pkg::SPEED_W-1:0] speed_left;
   logic signed [dwips_pkg::SPEED_W-1:0] speed_right;

   modport source (output valid, kind, line_error, speed_left, speed_right, input ready);
   modport sink   (input valid, kind, line_error, speed_left, speed_right, output ready);
endinterface

@@ design/dwips_rsp_if.sv @@
// ----------------------------------------------------------------------------
// dwips_rsp_if
// Result item channel: left and right PWM duty in whole counts.
// ----------------------------------------------------------------------------
interface dwips_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [dwips_pkg::DUTY_W-1:0] duty_left;
   logic [dwips_pkg::DUTY_W-1:0] duty_right;

   modport source (output valid, duty_left, duty_right, input ready);
   modport sink   (input valid, duty_left, duty_right, output ready);
endinterface

@@ design/dual_wheel_incremental_pi_speed.sv @@
// ----------------------------------------------------------------------------
// dual_wheel_incremental_pi_speed
// Two-wheel incremental PI speed controller with clamped Q12.8 duty accumulators.
// ----------------------------------------------------------------------------
// A track item runs the shared bit-serial multiplier for the steering offset
// and then once per wheel, a straight item once per wheel and a reset or
// restart item not at all. One item is in work at a time, so no new item is
// taken until the last one is through. Synchronous active-high reset clears
// the errors, loads both accumulators with the start duty of 1300 counts
// (saturated to DUTY_MAX) and sets the registers to their reset values.
module dual_wheel_incremental_pi_speed #(
   parameter int DUTY_MAX = 4000
) (
   input  logic                                  clock,
   input  logic                                  reset,
   dwips_req_if.sink                             req_chan,
   dwips_rsp_if.source                           rsp_chan,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [dwips_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [dwips_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [dwips_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                  csr_pready
);

   // The accumulator holds up to DUTY_MAX*256; its width follows from that.
   localparam int ACC_MAX = DUTY_MAX * 256;
   localparam int ACC_W   = $clog2(ACC_MAX + 1);
   localparam int EXT_W   = (ACC_W > 20) ? ACC_W : 20;
   localparam int SUM_W   = dwips_pkg::INC_W + 1;
   localparam int RST_ACC =
      ((dwips_pkg::START_DUTY_RST > DUTY_MAX) ? DUTY_MAX : dwips_pkg::START_DUTY_RST) * 256;

   // The sequencer walks through the offset product on a track item, then each wheel in turn.
   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_OFFSET = 9'b000000010,
      ST_ERR_L  = 9'b000000100,
      ST_MUL_L  = 9'b000001000,
      ST_ACC_L  = 9'b000010000,
      ST_ERR_R  = 9'b000100000,
      ST_MUL_R  = 9'b001000000,
      ST_ACC_R  = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Configuration registers.
   logic [dwips_pkg::GAIN_W-1:0] kp_ff;
   logic [dwips_pkg::GAIN_W-1:0] ki_ff;
   logic [dwips_pkg::BASE_W-1:0] base_ff;
   logic [dwips_pkg::GAIN_W-1:0] steer_ff;
   logic [dwips_pkg::DUTY_W-1:0] start_ff;
   logic                         csr_write;
   logic [2:0]                   csr_index;

   // Captured item and controller state.
   logic signed [dwips_pkg::SPEED_W-1:0] speed_l_ff;
   logic signed [dwips_pkg::SPEED_W-1:0] speed_r_ff;
   logic signed [dwips_pkg::OFF_W-1:0]   off_ff;
   logic signed [dwips_pkg::ERR_W-1:0]   prev_l_ff;
   logic signed [dwips_pkg::ERR_W-1:0]   prev_r_ff;
   logic [ACC_W-1:0]                     acc_l_ff;
   logic [ACC_W-1:0]                     acc_r_ff;
   logic                                 rsp_valid_ff;
   logic [dwips_pkg::DUTY_W-1:0]         duty_l_ff;
   logic [dwips_pkg::DUTY_W-1:0]         duty_r_ff;

   logic                                 req_fire;
   logic                                 is_left;
   logic signed [dwips_pkg::SPEED_W-1:0] speed_sel;
   logic signed [dwips_pkg::ERR_W-1:0]   prev_sel;
   logic signed [dwips_pkg::OPND_W-1:0]  err_wide;
   logic signed [dwips_pkg::ERR_W-1:0]   err_now;
   logic signed [dwips_pkg::OPND_W-1:0]  err_delta;
   logic [ACC_W-1:0]                     acc_sel;
   logic signed [SUM_W-1:0]              acc_sum;
   logic [ACC_W-1:0]                     acc_in;
   logic [EXT_W-1:0]                     ld_start;
   logic [ACC_W-1:0]                     start_acc;
   logic [EXT_W-1:0]                     acc_l_ext;
   logic [EXT_W-1:0]                     acc_r_ext;
   logic                                 out_free;

   dwips_pkg::mac_ctrl_type              mac_ctrl;
   dwips_pkg::mac_stat_type              mac_stat;
   logic signed [dwips_pkg::PROD_W-1:0]  mac_product;

   // ------------------------------------------------------------------------
   // Configuration port. Writes land on the access phase; reads are direct.
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff    <= '0;
         ki_ff    <= '0;
         base_ff  <= '0;
         steer_ff <= '0;
         start_ff <= dwips_pkg::DUTY_W'(dwips_pkg::START_DUTY_RST);
      end else if (csr_write) begin
         case (csr_index)
            dwips_pkg::REG_KP:    kp_ff    <= csr_pwdata[dwips_pkg::GAIN_W-1:0];
            dwips_pkg::REG_KI:    ki_ff    <= csr_pwdata[dwips_pkg::GAIN_W-1:0];
            dwips_pkg::REG_BASE:  base_ff  <= csr_pwdata[dwips_pkg::BASE_W-1:0];
            dwips_pkg::REG_STEER: steer_ff <= csr_pwdata[dwips_pkg::GAIN_W-1:0];
            dwips_pkg::REG_START: start_ff <= csr_pwdata[dwips_pkg::DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         dwips_pkg::REG_KP:    csr_prdata = dwips_pkg::CSR_DATA_W'(kp_ff);
         dwips_pkg::REG_KI:    csr_prdata = dwips_pkg::CSR_DATA_W'(ki_ff);
         dwips_pkg::REG_BASE:  csr_prdata = dwips_pkg::CSR_DATA_W'(base_ff);
         dwips_pkg::REG_STEER: csr_prdata = dwips_pkg::CSR_DATA_W'(steer_ff);
         dwips_pkg::REG_START: csr_prdata = dwips_pkg::CSR_DATA_W'(start_ff);
         default:              csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Error path. The same adders serve both wheels: the target is the base
   // speed less the steering offset on the left and plus it on the right.
   // ------------------------------------------------------------------------
   assign req_fire = req_chan.valid & req_chan.ready;
   assign is_left  = (state_ff == ST_ERR_L) || (state_ff == ST_ACC_L);

   always_comb begin
      speed_sel = is_left ? speed_l_ff : speed_r_ff;
      prev_sel  = is_left ? prev_l_ff : prev_r_ff;
      if (is_left) begin
         err_wide = dwips_pkg::OPND_W'($signed({1'b0, base_ff}))
                  - dwips_pkg::OPND_W'(off_ff) - dwips_pkg::OPND_W'(speed_sel);
      end else begin
         err_wide = dwips_pkg::OPND_W'($signed({1'b0, base_ff}))
                  + dwips_pkg::OPND_W'(off_ff) - dwips_pkg::OPND_W'(speed_sel);
      end
      err_now   = err_wide[dwips_pkg::ERR_W-1:0];
      err_delta = dwips_pkg::OPND_W'(err_now) - dwips_pkg::OPND_W'(prev_sel);
   end

   // ------------------------------------------------------------------------
   // Accumulator update: add the increment, which the product already carries
   // on the Q12.8 scale (dropping its low byte floors it), then clamp to 0..ACC_MAX.
   // ------------------------------------------------------------------------
   always_comb begin
      acc_sel = is_left ? acc_l_ff : acc_r_ff;
      acc_sum = SUM_W'($signed({1'b0, acc_sel}))
              + SUM_W'($signed(mac_product[dwips_pkg::PROD_W-1:8]));
      if (acc_sum < 0) begin
         acc_in = '0;
      end else if (acc_sum > SUM_W'(ACC_MAX)) begin
         acc_in = ACC_W'(ACC_MAX);
      end else begin
         acc_in = acc_sum[ACC_W-1:0];
      end
   end

   // Restart value: the start duty, saturated to the maximum duty.
   always_comb begin
      ld_start = EXT_W'({start_ff, 8'h00});
      if (ld_start > EXT_W'(ACC_MAX)) begin
         start_acc = ACC_W'(ACC_MAX);
      end else begin
         start_acc = ld_start[ACC_W-1:0];
      end
   end

   // ------------------------------------------------------------------------
   // Shared bit-serial multiplier. On a track item it first forms the
   // steering offset; for each wheel it forms kp*(change of error) + ki*error.
   // ------------------------------------------------------------------------
   always_comb begin
      mac_ctrl.start  = 1'b0;
      mac_ctrl.gain_a = kp_ff;
      mac_ctrl.gain_b = ki_ff;
      mac_ctrl.opnd_a = err_delta;
      mac_ctrl.opnd_b = dwips_pkg::OPND_W'(err_now);
      if (state_ff == ST_IDLE) begin
         mac_ctrl.start  = req_fire && (req_chan.kind == dwips_pkg::KIND_TRACK);
         mac_ctrl.gain_a = steer_ff;
         mac_ctrl.gain_b = '0;
         mac_ctrl.opnd_a = dwips_pkg::OPND_W'(req_chan.line_error);
         mac_ctrl.opnd_b = '0;
      end else if ((state_ff == ST_ERR_L) || (state_ff == ST_ERR_R)) begin
         mac_ctrl.start  = 1'b1;
      end
   end

   dwips_serial_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mac_ctrl),
      .stat    (mac_stat),
      .product (mac_product)
   );

   // ------------------------------------------------------------------------
   // Sequencer. The output register frees the sequencer to take the next
   // item while a finished result still waits on the result channel.
   // ------------------------------------------------------------------------
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_chan.kind)
                  dwips_pkg::KIND_TRACK:    state_in = ST_OFFSET;
                  dwips_pkg::KIND_STRAIGHT: state_in = ST_ERR_L;
                  default:                  state_in = ST_DONE;
               endcase
            end
         end
         ST_OFFSET: if (mac_stat.done) state_in = ST_ERR_L;
         ST_ERR_L:  state_in = ST_MUL_L;
         ST_MUL_L:  if (mac_stat.done) state_in = ST_ACC_L;
         ST_ACC_L:  state_in = ST_ERR_R;
         ST_ERR_R:  state_in = ST_MUL_R;
         ST_MUL_R:  if (mac_stat.done) state_in = ST_ACC_R;
         ST_ACC_R:  state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   assign req_chan.ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         prev_l_ff <= '0;
         prev_r_ff <= '0;
         acc_l_ff  <= ACC_W'(RST_ACC);
         acc_r_ff  <= ACC_W'(RST_ACC);
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  speed_l_ff <= req_chan.speed_left;
                  speed_r_ff <= req_chan.speed_right;
                  off_ff     <= '0;
                  if (req_chan.kind == dwips_pkg::KIND_ZERO) begin
                     prev_l_ff <= '0;
                     prev_r_ff <= '0;
                     acc_l_ff  <= '0;
                     acc_r_ff  <= '0;
                  end else if (req_chan.kind == dwips_pkg::KIND_RESTART) begin
                     prev_l_ff <= '0;
                     prev_r_ff <= '0;
                     acc_l_ff  <= start_acc;
                     acc_r_ff  <= start_acc;
                  end
               end
            end
            ST_OFFSET: begin
               if (mac_stat.done) off_ff <= mac_product[dwips_pkg::OFF_W-1:0];
            end
            ST_ERR_L: prev_l_ff <= err_now;
            ST_ACC_L: acc_l_ff  <= acc_in;
            ST_ERR_R: prev_r_ff <= err_now;
            ST_ACC_R: acc_r_ff  <= acc_in;
            default: ;
         endcase
      end
   end

   // Result register.
   assign acc_l_ext = EXT_W'(acc_l_ff);
   assign acc_r_ext = EXT_W'(acc_r_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_ff <= 1'b1;
         duty_l_ff    <= acc_l_ext[19:8];
         duty_r_ff    <= acc_r_ext[19:8];
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.duty_left  = duty_l_ff;
   assign rsp_chan.duty_right = duty_r_ff;

`ifndef SYNTHESIS
   // The accumulators never leave their clamp range.
   assert property (@(posedge clock) disable iff (reset)
      (acc_l_ff <= ACC_W'(ACC_MAX)) && (acc_r_ff <= ACC_W'(ACC_MAX)))
      else $error("duty accumulator above its maximum");

   // No item is taken while the multiplier is still at work.
   assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !mac_stat.busy)
      else $error("item accepted while multiplier busy");

   // A reset item zeroes both accumulators at once.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_chan.kind == dwips_pkg::KIND_ZERO))
      |=> ((acc_l_ff == '0) && (acc_r_ff == '0) && (state_ff == ST_DONE)))
      else $error("reset item did not clear the accumulators");

   // The multiplier finishes only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      mac_stat.done |-> ((state_ff == ST_OFFSET) || (state_ff == ST_MUL_L)
                         || (state_ff == ST_MUL_R)))
      else $error("multiplier finished outside a multiply state");
`endif

endmodule

@@ design/dwips_serial_mac.sv @@
// ----------------------------------------------------------------------------
// dwips_serial_mac
// Bit-serial multiply-accumulate: gain_a*opnd_a + gain_b*opnd_b, one gain bit
// per cycle, the product shifting out through a shift register.
// ----------------------------------------------------------------------------
module dwips_serial_mac (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dwips_pkg::mac_ctrl_type              ctrl,
   output dwips_pkg::mac_stat_type              stat,
   output logic signed [dwips_pkg::PROD_W-1:0]  product
);

   logic [dwips_pkg::GAIN_W-1:0]        gain_a_ff;
   logic [dwips_pkg::GAIN_W-1:0]        gain_b_ff;
   logic signed [dwips_pkg::OPND_W-1:0] opnd_a_ff;
   logic signed [dwips_pkg::OPND_W-1:0] opnd_b_ff;
   logic signed [dwips_pkg::HI_W-1:0]   hi_ff;
   logic [dwips_pkg::GAIN_W-1:0]        lo_ff;
   logic [dwips_pkg::CNT_W-1:0]         cnt_ff;
   logic                                busy_ff;
   logic                                done_ff;
   logic signed [dwips_pkg::HI_W-1:0]   sum_in;
   logic signed [dwips_pkg::HI_W-1:0]   add_a;
   logic signed [dwips_pkg::HI_W-1:0]   add_b;

   always_comb begin
      add_a  = gain_a_ff[0] ? dwips_pkg::HI_W'(opnd_a_ff) : '0;
      add_b  = gain_b_ff[0] ? dwips_pkg::HI_W'(opnd_b_ff) : '0;
      sum_in = hi_ff + add_a + add_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (ctrl.start) begin
         busy_ff   <= 1'b1;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
         gain_a_ff <= ctrl.gain_a;
         gain_b_ff <= ctrl.gain_b;
         opnd_a_ff <= ctrl.opnd_a;
         opnd_b_ff <= ctrl.opnd_b;
         hi_ff     <= '0;
         lo_ff     <= '0;
      end else if (busy_ff) begin
         gain_a_ff <= gain_a_ff >> 1;
         gain_b_ff <= gain_b_ff >> 1;
         hi_ff     <= sum_in >>> 1;
         lo_ff     <= {sum_in[0], lo_ff[dwips_pkg::GAIN_W-1:1]};
         cnt_ff    <= cnt_ff + 1'b1;
         if (cnt_ff == dwips_pkg::CNT_W'(dwips_pkg::GAIN_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign product   = {hi_ff, lo_ff};

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-wheel incremental PI speed controller. A
// directed run covers the field extremes, every kind and the saturation and
// rounding corners. Random runs then follow under several gain settings. A
// predictor tracks both duty accumulators and checks every result item.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int     DUTY_MAX       = 4000;
   localparam longint ACC_MAX        = longint'(DUTY_MAX) * 256;
   localparam int     CLOCK_PERIOD   = 20;
   localparam int     TIMEOUT_CYCLES = 1_200_000;
   localparam int     SETTLE_CYCLES  = 60;
   localparam int     ITEMS_PER_RUN  = 206;
   localparam int     HOLD_OFF_CYCLES = 400;
   localparam int     MAX_REPORTS    = 10;

   // Register indexes that decode to nothing; writes there must be dropped.
   localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
   localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

   typedef struct {
      dwips_pkg::kind_type                  kind;
      logic signed [dwips_pkg::LERR_W-1:0]  line_error;
      logic signed [dwips_pkg::SPEED_W-1:0] speed_left;
      logic signed [dwips_pkg::SPEED_W-1:0] speed_right;
   } speed_sample_type;

   typedef struct {
      logic [dwips_pkg::DUTY_W-1:0] left;
      logic [dwips_pkg::DUTY_W-1:0] right;
   } duty_pair_type;

   logic                             clock;
   logic                             reset;
   logic                             csr_psel;
   logic                             csr_penable;
   logic                             csr_pwrite;
   logic [dwips_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [dwips_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [dwips_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                             csr_pready;

   dwips_req_if req_bus ();
   dwips_rsp_if rsp_bus ();

   dual_wheel_incremental_pi_speed #(
      .DUTY_MAX (DUTY_MAX)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Items waiting to be offered, and duty pairs waiting to come back.
   speed_sample_type pending_samples[$];
   duty_pair_type    expected_duties[$];

   // Predictor copy of the registers and of the controller state.
   longint gain_kp;
   longint gain_ki;
   longint base_target;
   longint gain_steer;
   longint start_counts;
   longint last_err_left;
   longint last_err_right;
   longint acc_left;
   longint acc_right;

   int               failures;
   bit               idle_on;
   speed_sample_type offered_sample;
   int               send_gap;
   int               stall_left;
   int               pressure_left;
   int               handshakes_seen;
   duty_pair_type    oldest_duty;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // The start duty is loaded in Q12.8 and saturated at the top of the range.
   function automatic longint start_acc();
      longint v;
      v = start_counts * 256;
      return (v > ACC_MAX) ? ACC_MAX : v;
   endfunction

   // One incremental PI update of a wheel accumulator. The products are
   // formed at 64 bits so nothing wraps, and the arithmetic shift rounds a
   // negative increment towards minus infinity.
   function automatic longint next_acc(longint err, longint last_err, longint acc);
      longint sum;
      longint a;
      sum = gain_kp * (err - last_err) + gain_ki * err;
      a = acc + (sum >>> 8);
      if (a < 0) a = 0;
      if (a > ACC_MAX) a = ACC_MAX;
      return a;
   endfunction

   // Advances the controller by one control period and returns the duties.
   function automatic duty_pair_type control_period(speed_sample_type s);
      longint        offset;
      longint        err_left;
      longint        err_right;
      duty_pair_type d;
      if (s.kind == dwips_pkg::KIND_STRAIGHT || s.kind == dwips_pkg::KIND_TRACK) begin
         // In track mode the line error pulls the two targets apart.
         offset = (s.kind == dwips_pkg::KIND_TRACK) ?
                  longint'(s.line_error) * gain_steer : 0;
         err_left  = base_target - offset - longint'(s.speed_left);
         err_right = base_target + offset - longint'(s.speed_right);
         acc_left  = next_acc(err_left, last_err_left, acc_left);
         acc_right = next_acc(err_right, last_err_right, acc_right);
         last_err_left  = err_left;
         last_err_right = err_right;
      end else begin
         // Zero and restart kinds ignore the speeds and the line error.
         last_err_left  = 0;
         last_err_right = 0;
         acc_left  = (s.kind == dwips_pkg::KIND_ZERO) ? 0 : start_acc();
         acc_right = acc_left;
      end
      d.left  = acc_left[dwips_pkg::DUTY_W+7:8];
      d.right = acc_right[dwips_pkg::DUTY_W+7:8];
      return d;
   endfunction

   function automatic void apply_register(logic [2:0] idx,
                                          logic [dwips_pkg::CSR_DATA_W-1:0] value);
      case (idx)
         dwips_pkg::REG_KP:    gain_kp      = longint'(value[dwips_pkg::GAIN_W-1:0]);
         dwips_pkg::REG_KI:    gain_ki      = longint'(value[dwips_pkg::GAIN_W-1:0]);
         dwips_pkg::REG_BASE:  base_target  = longint'(value[dwips_pkg::BASE_W-1:0]);
         dwips_pkg::REG_STEER: gain_steer   = longint'(value[dwips_pkg::GAIN_W-1:0]);
         dwips_pkg::REG_START: start_counts = longint'(value[dwips_pkg::DUTY_W-1:0]);
         default: begin
         end
      endcase
   endfunction

   function automatic void log_failure(string what);
      failures++;
      if (failures <= MAX_REPORTS)
         $display("%0t: %s", $realtime, what);
   endfunction

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int draw_pause();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 100);
   endfunction

   // A speed a little either side of the given target.
   function automatic logic signed [dwips_pkg::SPEED_W-1:0] speed_near(longint target);
      return dwips_pkg::SPEED_W'(target + longint'($urandom_range(0, 4095)) - 2048);
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // Register write: a setup cycle, then an access cycle that completes on
   // the edge at which pready is seen high.
   task automatic write_register(input logic [2:0] idx,
                                 input logic [dwips_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      apply_register(idx, value);
   endtask

   task automatic program_gains(input logic [dwips_pkg::CSR_DATA_W-1:0] kp,
                                input logic [dwips_pkg::CSR_DATA_W-1:0] ki,
                                input logic [dwips_pkg::CSR_DATA_W-1:0] base,
                                input logic [dwips_pkg::CSR_DATA_W-1:0] steer,
                                input logic [dwips_pkg::CSR_DATA_W-1:0] start);
      write_register(dwips_pkg::REG_KP, kp);
      write_register(dwips_pkg::REG_KI, ki);
      write_register(dwips_pkg::REG_BASE, base);
      write_register(dwips_pkg::REG_STEER, steer);
      write_register(dwips_pkg::REG_START, start);
   endtask

   task automatic queue_sample(input dwips_pkg::kind_type kind, input int lerr,
                               input longint left, input longint right);
      speed_sample_type s;
      s.kind        = kind;
      s.line_error  = dwips_pkg::LERR_W'(lerr);
      s.speed_left  = dwips_pkg::SPEED_W'(left);
      s.speed_right = dwips_pkg::SPEED_W'(right);
      pending_samples.push_back(s);
   endtask

   // Random items. Most sit close to the current wheel targets so that the
   // accumulators wander through the range rather than pinning at a rail.
   task automatic queue_random_samples(input int count);
      speed_sample_type s;
      int               pick;
      longint           offset;
      @(negedge clock);
      repeat (count) begin
         pick = $urandom_range(0, 99);
         s.kind = (pick < 42) ? dwips_pkg::KIND_STRAIGHT :
                  (pick < 84) ? dwips_pkg::KIND_TRACK :
                  (pick < 90) ? dwips_pkg::KIND_ZERO : dwips_pkg::KIND_RESTART;
         s.line_error = dwips_pkg::LERR_W'($urandom);
         offset = (s.kind == dwips_pkg::KIND_TRACK) ?
                  longint'(s.line_error) * gain_steer : 0;
         if ($urandom_range(0, 99) < 75) begin
            s.speed_left  = speed_near(base_target - offset);
            s.speed_right = speed_near(base_target + offset);
         end else begin
            s.speed_left  = dwips_pkg::SPEED_W'($urandom);
            s.speed_right = dwips_pkg::SPEED_W'($urandom);
         end
         pending_samples.push_back(s);
      end
   endtask

   // Returns once every item has been taken and every result has come back.
   task automatic wait_until_drained();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_bus.valid || expected_duties.size() != 0);
   endtask

   // ------------------------------------------------------------------------
   // Clock and run limit
   // ------------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(CLOCK_PERIOD * TIMEOUT_CYCLES);
      $display("== FAIL ==");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Driver: offers queued items, with random gaps after each acceptance.
   // The expected duties are worked out at the edge the item is taken.
   // ------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid       <= 1'b0;
         req_bus.kind        <= '0;
         req_bus.line_error  <= '0;
         req_bus.speed_left  <= '0;
         req_bus.speed_right <= '0;
         send_gap = 0;
      end else if (!(req_bus.valid && !req_bus.ready)) begin
         if (req_bus.valid)
            expected_duties.push_back(control_period(offered_sample));
         if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_samples.size() != 0) begin
            offered_sample = pending_samples.pop_front();
            req_bus.valid       <= 1'b1;
            req_bus.kind        <= offered_sample.kind;
            req_bus.line_error  <= offered_sample.line_error;
            req_bus.speed_left  <= offered_sample.speed_left;
            req_bus.speed_right <= offered_sample.speed_right;
            send_gap = idle_on ? draw_pause() : 0;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: checks each result item against the oldest expectation and
   // drives ready with random stalls.
   // ------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_duties.size() == 0) begin
               log_failure($sformatf("result item with nothing expected: left %0d right %0d",
                                     rsp_bus.duty_left, rsp_bus.duty_right));
            end else begin
               oldest_duty = expected_duties.pop_front();
               if (rsp_bus.duty_left !== oldest_duty.left ||
                   rsp_bus.duty_right !== oldest_duty.right)
                  log_failure($sformatf("duty mismatch: expected %0d/%0d, got %0d/%0d",
                                        oldest_duty.left, oldest_duty.right,
                                        rsp_bus.duty_left, rsp_bus.duty_right));
            end
         end
         if (pressure_left > 0) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            stall_left = idle_on ? draw_pause() : 0;
            rsp_bus.ready <= (stall_left == 0);
         end
      end
   end

   // Back-pressure: twice in the random part the receiver holds ready low for
   // a long stretch while the sender keeps offering, so the controller ends
   // up holding a finished result and must refuse further input items.
   always @(posedge clock) begin
      if (reset) begin
         pressure_left <= 0;
         handshakes_seen = 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            handshakes_seen++;
         if (pressure_left > 0)
            pressure_left <= pressure_left - 1;
         else if (req_bus.valid && req_bus.ready &&
                  (handshakes_seen == 300 || handshakes_seen == 800))
            pressure_left <= HOLD_OFF_CYCLES;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence of the run
   // ------------------------------------------------------------------------

   initial begin
      reset               = 1'b1;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      failures            = 0;
      idle_on             = 1'b1;

      // Predictor state after reset: zero gains, start duty of 1300 counts.
      gain_kp        = 0;
      gain_ki        = 0;
      base_target    = 0;
      gain_steer     = 0;
      start_counts   = dwips_pkg::START_DUTY_RST;
      last_err_left  = 0;
      last_err_right = 0;
      acc_left       = start_acc();
      acc_right      = start_acc();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // With the reset registers an ordinary step must leave the start duty.
      @(negedge clock);
      queue_sample(dwips_pkg::KIND_STRAIGHT, 0, 0, 0);
      wait_until_drained();

      // Moderate gains. The spare register indexes take junk that must not
      // land in any real register.
      program_gains(32'h0180, 32'h0040, 100 * 256, 32'h0200, 2000);
      write_register(REG_SPARE_FIRST, 32'hFFFF_FFFF);
      write_register(REG_SPARE_LAST, 32'h1234_5678);
      @(negedge clock);
      queue_sample(dwips_pkg::KIND_RESTART, 0, 0, 0);
      queue_sample(dwips_pkg::KIND_STRAIGHT, 0, 0, 0);
      queue_sample(dwips_pkg::KIND_STRAIGHT, 0, 8388607, 8388607);
      queue_sample(dwips_pkg::KIND_STRAIGHT, 0, -8388608, -8388608);
      queue_sample(dwips_pkg::KIND_TRACK, -128, 100 * 256, 100 * 256);
      queue_sample(dwips_pkg::KIND_TRACK, 127, 0, -1);
      queue_sample(dwips_pkg::KIND_TRACK, 0, 100 * 256, 99 * 256);
      queue_sample(dwips_pkg::KIND_ZERO, -1, 8388607, -8388608);
      // A one-count overshoot must pull the duty down by a floored step.
      queue_sample(dwips_pkg::KIND_RESTART, 5, 1234, 4321);
      queue_sample(dwips_pkg::KIND_STRAIGHT, 0, 100 * 256 + 1, 100 * 256 + 1);
      queue_sample(dwips_pkg::KIND_STRAIGHT, 0, 100 * 256, 100 * 256);
      wait_until_drained();

      // Every register at its top; the start duty then saturates at DUTY_MAX.
      program_gains(32'hFFFF, 32'hFFFF, 32'h7F_FFFF, 32'hFFFF, 32'hFFF);
      @(negedge clock);
      queue_sample(dwips_pkg::KIND_RESTART, 0, 0, 0);
      queue_sample(dwips_pkg::KIND_TRACK, -128, -8388608, -8388608);
      queue_sample(dwips_pkg::KIND_TRACK, 127, 8388607, 8388607);
      queue_sample(dwips_pkg::KIND_STRAIGHT, 0, -8388608, 8388607);
      queue_sample(dwips_pkg::KIND_ZERO, 127, 0, 0);
      queue_sample(dwips_pkg::KIND_STRAIGHT, -128, 8388607, 8388607);
      queue_sample(dwips_pkg::KIND_TRACK, -1, 24'h555555, 24'hAAAAAA);
      wait_until_drained();

      // Random part, one run per register setting.
      program_gains($urandom_range(64, 1024), $urandom_range(1, 256),
                    $urandom_range(0, 200 * 256), $urandom_range(0, 2048),
                    $urandom_range(0, 4000));
      queue_random_samples(ITEMS_PER_RUN);
      wait_until_drained();

      // All zero, with no idling on either side.
      idle_on = 1'b0;
      program_gains(0, 0, 0, 0, 0);
      queue_random_samples(ITEMS_PER_RUN);
      wait_until_drained();
      idle_on = 1'b1;

      program_gains($urandom_range(16, 512), $urandom_range(1, 128),
                    $urandom_range(0, 8388607), $urandom_range(0, 65535),
                    $urandom_range(0, 4095));
      queue_random_samples(ITEMS_PER_RUN);
      wait_until_drained();

      program_gains(32'hFFFF, 32'hFFFF, 32'h7F_FFFF, 32'hFFFF, 32'hFFF);
      queue_random_samples(ITEMS_PER_RUN);
      wait_until_drained();

      // Whole 32-bit words, so the bits above each register are exercised too.
      program_gains($urandom, $urandom, $urandom, $urandom, $urandom);
      queue_random_samples(ITEMS_PER_RUN);
      wait_until_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_duties.size() != 0)
         log_failure($sformatf("%0d result items never arrived", expected_duties.size()));

      if (failures == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
